>>> hw/rtl/lswc_pkg.sv
// ----------------------------------------------------------------------------
// lswc_pkg
// shared types and constants for the lifo stack with match count
// ----------------------------------------------------------------------------
package lswc_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int FILL_W        = 7;
   localparam int STATUS_W      = 2;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_COUNT = 2'd3
   } op_type;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      op_type                    operation;
      logic signed [DATA_W-1:0]  operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_value;
      logic [STATUS_W-1:0]       status;
      logic [FILL_W-1:0]         fill_level;
   } rsp_type;

   // shift commands to the cell ring
   typedef struct packed {
      logic shift_down;   // push: every cell takes its upper neighbour, the top cell the operand
      logic shift_up;     // pop or rotate: every cell takes its lower neighbour
   } shift_ctrl_type;

endpackage

>>> hw/rtl/lswc_cell.sv
// ----------------------------------------------------------------------------
// lswc_cell
// one storage cell of the stack ring
// ----------------------------------------------------------------------------
module lswc_cell
   import lswc_pkg::*;
(
   input  logic                      clock,
   input  shift_ctrl_type            shift,
   input  logic signed [DATA_W-1:0]  from_above,
   input  logic signed [DATA_W-1:0]  from_below,
   output logic signed [DATA_W-1:0]  data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift.shift_down) begin
         data_in = from_above;
      end else if (shift.shift_up) begin
         data_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hw/rtl/lswc_seq.sv
// ----------------------------------------------------------------------------
// lswc_seq
// command sequencer: fill count, count walk and result register
// ----------------------------------------------------------------------------
module lswc_seq
   import lswc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp,
   input  logic signed [DATA_W-1:0]  top_data,
   output shift_ctrl_type            shift
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
   localparam logic [CntW-1:0] OneCnt   = CntW'(1);

   typedef enum logic {
      ST_IDLE,
      ST_COUNT
   } state_type;

   state_type                 state_ff,  state_in;
   logic [CntW-1:0]           fill_ff,   fill_in;
   logic [CntW-1:0]           step_ff,   step_in;
   logic [CntW-1:0]           match_ff,  match_in;
   logic signed [DATA_W-1:0]  key_ff,    key_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff,    rsp_in;

   logic                      rsp_free;
   logic [CntW-1:0]           fill_inc;
   logic [CntW-1:0]           fill_dec;
   logic [CntW+FILL_W-1:0]    lvl_cur_wide;
   logic [CntW+FILL_W-1:0]    lvl_inc_wide;
   logic [CntW+FILL_W-1:0]    lvl_dec_wide;
   logic [CntW+DATA_W-1:0]    match_wide;

   assign fill_inc     = fill_ff + OneCnt;
   assign fill_dec     = fill_ff - OneCnt;
   assign lvl_cur_wide = {{FILL_W{1'b0}}, fill_ff};
   assign lvl_inc_wide = {{FILL_W{1'b0}}, fill_inc};
   assign lvl_dec_wide = {{FILL_W{1'b0}}, fill_dec};
   assign match_wide   = {{DATA_W{1'b0}}, match_ff};

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      match_in     = match_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      shift        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in.result_value = '0;
               rsp_in.status       = STATUS_OK;
               rsp_in.fill_level   = lvl_cur_wide[FILL_W-1:0];
               rsp_valid_in        = 1'b1;
               unique case (req.operation)
                  OP_PUSH: begin
                     if (fill_ff == DepthCnt) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        shift.shift_down  = 1'b1;
                        fill_in           = fill_inc;
                        rsp_in.fill_level = lvl_inc_wide[FILL_W-1:0];
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        shift.shift_up      = 1'b1;
                        fill_in             = fill_dec;
                        rsp_in.result_value = top_data;
                        rsp_in.fill_level   = lvl_dec_wide[FILL_W-1:0];
                     end
                  end
                  OP_PEEK: begin
                     if (fill_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_in.result_value = top_data;
                     end
                  end
                  OP_COUNT: begin
                     rsp_in       = rsp_ff;
                     rsp_valid_in = 1'b0;
                     key_in       = req.operand;
                     step_in      = '0;
                     match_in     = '0;
                     state_in     = ST_COUNT;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            if (step_ff != DepthCnt) begin
               // rotate once; the cell at the top holds the entry step_ff below top
               shift.shift_up = 1'b1;
               step_in        = step_ff + OneCnt;
               if ((top_data == key_ff) && (step_ff < fill_ff)) begin
                  match_in = match_ff + OneCnt;
               end
            end else if (rsp_free) begin
               rsp_in.result_value = match_wide[DATA_W-1:0];
               rsp_in.status       = STATUS_OK;
               rsp_in.fill_level   = lvl_cur_wide[FILL_W-1:0];
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff  <= step_in;
      match_ff <= match_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> hw/rtl/lifo_stack_with_count.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_count
// lifo stack of signed words held in a ring of cells, with a match count
// ----------------------------------------------------------------------------
// push, pop and peek: result registered, valid in the cycle after the transaction
// count: DEPTH rotations of the cell ring, one per cycle, then the result is registered when the output is free
// next transaction taken once the previous command has finished and its result
// is leaving or gone: push, pop and peek one per cycle while rsp_ready is high
// reset empties the stack at once; cell contents are not cleared
module lifo_stack_with_count
   import lswc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   // cell 0 is the top of stack; the ring closes from the last cell back to cell 0
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   shift_ctrl_type           shift;

   // sequencer: fill count, command decode, count walk and output register
   lswc_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .top_data  (cell_data[0]),
      .shift     (shift)
   );

   // the chain of cells
   // push shifts every entry one place down and loads the operand on top
   // pop shifts every entry one place up; the last cell takes the old top
   // count rotates the ring DEPTH times, so the stack ends where it started
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] above;

      if (i == 0) begin : g_top
         assign above = req.operand;
      end else begin : g_inner
         assign above = cell_data[i-1];
      end

      lswc_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (cell_data[(i + 1) % DEPTH]),
         .data       (cell_data[i])
      );
   end

endmodule
